FILE: rtl/ecdsa_der_pkg.sv
`timescale 1ns / 1ps
package ecdsa_der_pkg;

    // Signature geometry
    localparam int INTEGER_BYTES = 32;
    localparam int SIG_BYTES     = 2 * INTEGER_BYTES;
    localparam int SIG_WORDS     = (SIG_BYTES + 7) / 8;
    localparam int MAX_TOTAL     = SIG_BYTES + 8;

    // Widths
    localparam int WORD_W  = 64;
    localparam int VB_W    = 4;
    localparam int TOT_W   = 7;
    localparam int PTR_W   = $clog2(SIG_BYTES);
    localparam int WADDR_W = PTR_W - 3;
    localparam int CNT_W   = $clog2(INTEGER_BYTES + 1);
    localparam int ILEN_W  = $clog2(INTEGER_BYTES + 2);

    // DER codes
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] PAD_BYTE     = 8'h00;
    localparam logic [7:0] SIGN_MASK    = 8'h80;

    // One encoded byte on its way from the sequencer to the word packer
    typedef struct packed {
        logic             vld;
        logic [7:0]       data;
        logic             fin;
        logic [TOT_W-1:0] total;
    } der_byte_t;

endpackage

FILE: rtl/ecdsa_der_in_if.sv
`timescale 1ns / 1ps
interface ecdsa_der_in_if import ecdsa_der_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] sig_word;

    modport source (output valid, output sig_word, input ready);
    modport sink   (input valid, input sig_word, output ready);
endinterface

FILE: rtl/ecdsa_der_out_if.sv
`timescale 1ns / 1ps
interface ecdsa_der_out_if import ecdsa_der_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] der_word;
    logic [VB_W-1:0]   valid_bytes;
    logic [TOT_W-1:0]  total_length;
    logic              last_word;

    modport source (output valid, output der_word, output valid_bytes,
                    output total_length, output last_word, input ready);
    modport sink   (input valid, input der_word, input valid_bytes,
                    input total_length, input last_word, output ready);
endinterface

FILE: rtl/ecdsa_der_seq.sv
`timescale 1ns / 1ps
module ecdsa_der_seq import ecdsa_der_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    ecdsa_der_in_if.sink   sig,
    output der_byte_t      emit,
    input  logic           emit_ready
);

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_SCAN_R = 4'd1;
    localparam logic [3:0] ST_SCAN_S = 4'd2;
    localparam logic [3:0] ST_HDR    = 4'd3;
    localparam logic [3:0] ST_SEQLEN = 4'd4;
    localparam logic [3:0] ST_TAG_R  = 4'd5;
    localparam logic [3:0] ST_LEN_R  = 4'd6;
    localparam logic [3:0] ST_PAD_R  = 4'd7;
    localparam logic [3:0] ST_DAT_R  = 4'd8;
    localparam logic [3:0] ST_TAG_S  = 4'd9;
    localparam logic [3:0] ST_LEN_S  = 4'd10;
    localparam logic [3:0] ST_PAD_S  = 4'd11;
    localparam logic [3:0] ST_DAT_S  = 4'd12;

    logic [WORD_W-1:0]  mem [SIG_WORDS];
    logic [WORD_W-1:0]  rd_word_reg;

    logic [3:0]         state_reg, state_next;
    logic [WADDR_W-1:0] wcnt_reg, wcnt_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   zr_reg, zr_next;
    logic [CNT_W-1:0]   zs_reg, zs_next;
    logic               pad_r_reg, pad_r_next;
    logic               pad_s_reg, pad_s_next;

    logic [7:0]         cur_byte;
    logic [CNT_W-1:0]   kept_r, kept_s;
    logic [ILEN_W-1:0]  len_r, len_s;
    logic [TOT_W-1:0]   seq_len, total;
    logic               cur_zero;

    // Pick the byte under the pointer from the registered word
    assign cur_byte = rd_word_reg[{~ptr_reg[2:0], 3'b000} +: 8];
    assign cur_zero = (cur_byte == 8'h00);

    // Encoded lengths
    assign kept_r  = CNT_W'(INTEGER_BYTES) - zr_reg;
    assign kept_s  = CNT_W'(INTEGER_BYTES) - zs_reg;
    assign len_r   = ILEN_W'(kept_r) + ILEN_W'(pad_r_reg);
    assign len_s   = ILEN_W'(kept_s) + ILEN_W'(pad_s_reg);
    assign seq_len = TOT_W'(len_r) + TOT_W'(len_s) + TOT_W'(4);
    assign total   = seq_len + TOT_W'(2);

    assign sig.ready = (state_reg == ST_LOAD);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        wcnt_next  = wcnt_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        zr_next    = zr_reg;
        zs_next    = zs_reg;
        pad_r_next = pad_r_reg;
        pad_s_next = pad_s_reg;
        emit.vld   = 1'b0;
        emit.data  = PAD_BYTE;
        emit.fin   = 1'b0;
        emit.total = total;

        unique case (state_reg)
            ST_LOAD:
            begin
                ptr_next = '0;
                cnt_next = '0;
                if (sig.valid)
                begin
                    if (wcnt_reg == WADDR_W'(SIG_WORDS - 1))
                    begin
                        wcnt_next  = '0;
                        state_next = ST_SCAN_R;
                    end
                    else
                    begin
                        wcnt_next = wcnt_reg + WADDR_W'(1);
                    end
                end
            end
            ST_SCAN_R:
            begin
                if (cur_zero && (cnt_reg != CNT_W'(INTEGER_BYTES - 1)))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    ptr_next = ptr_reg + PTR_W'(1);
                end
                else
                begin
                    zr_next    = cnt_reg;
                    pad_r_next = |(cur_byte & SIGN_MASK);
                    cnt_next   = '0;
                    ptr_next   = PTR_W'(INTEGER_BYTES);
                    state_next = ST_SCAN_S;
                end
            end
            ST_SCAN_S:
            begin
                if (cur_zero && (cnt_reg != CNT_W'(INTEGER_BYTES - 1)))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    ptr_next = ptr_reg + PTR_W'(1);
                end
                else
                begin
                    zs_next    = cnt_reg;
                    pad_s_next = |(cur_byte & SIGN_MASK);
                    ptr_next   = PTR_W'(zr_reg);
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                emit.vld  = 1'b1;
                emit.data = TAG_SEQUENCE;
                if (emit_ready)
                    state_next = ST_SEQLEN;
            end
            ST_SEQLEN:
            begin
                emit.vld  = 1'b1;
                emit.data = 8'(seq_len);
                if (emit_ready)
                    state_next = ST_TAG_R;
            end
            ST_TAG_R:
            begin
                emit.vld  = 1'b1;
                emit.data = TAG_INTEGER;
                if (emit_ready)
                    state_next = ST_LEN_R;
            end
            ST_LEN_R:
            begin
                emit.vld  = 1'b1;
                emit.data = 8'(len_r);
                if (emit_ready)
                begin
                    cnt_next   = kept_r;
                    state_next = pad_r_reg ? ST_PAD_R : ST_DAT_R;
                end
            end
            ST_PAD_R:
            begin
                emit.vld  = 1'b1;
                emit.data = PAD_BYTE;
                if (emit_ready)
                    state_next = ST_DAT_R;
            end
            ST_DAT_R:
            begin
                emit.vld  = 1'b1;
                emit.data = cur_byte;
                if (emit_ready)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        ptr_next   = PTR_W'(INTEGER_BYTES) + PTR_W'(zs_reg);
                        state_next = ST_TAG_S;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
            end
            ST_TAG_S:
            begin
                emit.vld  = 1'b1;
                emit.data = TAG_INTEGER;
                if (emit_ready)
                    state_next = ST_LEN_S;
            end
            ST_LEN_S:
            begin
                emit.vld  = 1'b1;
                emit.data = 8'(len_s);
                if (emit_ready)
                begin
                    cnt_next   = kept_s;
                    state_next = pad_s_reg ? ST_PAD_S : ST_DAT_S;
                end
            end
            ST_PAD_S:
            begin
                emit.vld  = 1'b1;
                emit.data = PAD_BYTE;
                if (emit_ready)
                    state_next = ST_DAT_S;
            end
            ST_DAT_S:
            begin
                emit.vld  = 1'b1;
                emit.data = cur_byte;
                emit.fin  = (cnt_reg == CNT_W'(1));
                if (emit_ready)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        ptr_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Signature store: write incoming words, read the word under the next pointer
    always_ff @(posedge clk)
    begin
        if (sig.valid && sig.ready)
            mem[wcnt_reg] <= sig.sig_word;
        rd_word_reg <= mem[ptr_next[PTR_W-1:3]];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            wcnt_reg  <= '0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            zr_reg    <= '0;
            zs_reg    <= '0;
            pad_r_reg <= 1'b0;
            pad_s_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wcnt_reg  <= wcnt_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            zr_reg    <= zr_next;
            zs_reg    <= zs_next;
            pad_r_reg <= pad_r_next;
            pad_s_reg <= pad_s_next;
        end
    end

endmodule

FILE: rtl/ecdsa_der_pack.sv
`timescale 1ns / 1ps
module ecdsa_der_pack import ecdsa_der_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  der_byte_t       emit,
    output logic            emit_ready,
    ecdsa_der_out_if.source der
);

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [2:0]        lane_reg, lane_next;
    logic              out_vld_reg, out_vld_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [VB_W-1:0]   vb_reg, vb_next;
    logic [TOT_W-1:0]  tot_reg, tot_next;
    logic              last_reg, last_next;

    logic [WORD_W-1:0] acc_with;
    logic              word_done;
    logic              take;

    // Append the byte at the current lane; hand off a full or final word
    always_comb
    begin
        acc_with = acc_reg;
        acc_with[{~lane_reg, 3'b000} +: 8] = emit.data;

        word_done  = emit.vld && ((lane_reg == 3'b111) || emit.fin);
        emit_ready = !(word_done && out_vld_reg && !der.ready);
        take       = emit.vld && emit_ready;

        acc_next     = acc_reg;
        lane_next    = lane_reg;
        word_next    = word_reg;
        vb_next      = vb_reg;
        tot_next     = tot_reg;
        last_next    = last_reg;
        out_vld_next = out_vld_reg && !der.ready;

        if (take)
        begin
            if (word_done)
            begin
                word_next    = acc_with;
                vb_next      = VB_W'(lane_reg) + VB_W'(1);
                tot_next     = emit.total;
                last_next    = emit.fin;
                out_vld_next = 1'b1;
                acc_next     = '0;
                lane_next    = '0;
            end
            else
            begin
                acc_next  = acc_with;
                lane_next = lane_reg + 3'b001;
            end
        end
    end

    assign der.valid        = out_vld_reg;
    assign der.der_word     = word_reg;
    assign der.valid_bytes  = vb_reg;
    assign der.total_length = tot_reg;
    assign der.last_word    = last_reg;

    // Output payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        vb_reg   <= vb_next;
        tot_reg  <= tot_next;
        last_reg <= last_next;
    end

    // Control and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            lane_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            lane_reg    <= lane_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

FILE: rtl/ecdsa_raw_to_der_signature_unit.sv
`timescale 1ns / 1ps
// Channel  Role    Payload                                               Handshake
// sig      sink    sig_word[63:0]                                        valid/ready
// der      source  der_word[63:0] valid_bytes[3:0] total_length[6:0]    valid/ready
//                  last_word
//
// Eight words load at one per cycle. The sequencer then scans r and s one byte per
// cycle through a single read port on the signature store, and emits the encoding
// one byte per cycle while der does not stall (8 to 72 bytes). Each stripped zero
// adds a scan step and removes an emitted byte; each pad byte adds an emitted byte.
// rst_n clears all control state asynchronously. A stall on der holds the byte
// stream; a new signature loads while the final word still waits.
module ecdsa_raw_to_der_signature_unit import ecdsa_der_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    ecdsa_der_in_if.sink    sig,
    ecdsa_der_out_if.source der
);

    der_byte_t emit;
    logic      emit_ready;

    ecdsa_der_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .sig        (sig),
        .emit       (emit),
        .emit_ready (emit_ready)
    );

    ecdsa_der_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .emit_ready (emit_ready),
        .der        (der)
    );

    // Loading a new signature only overlaps the final word of the previous one
    a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (sig.ready && der.valid) |-> der.last_word)
        else $error("new signature loading while encoding still pending");

    // Only the final word may be short
    a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
        (der.valid && !der.last_word) |-> (der.valid_bytes == VB_W'(8)))
        else $error("short word before end of encoding");

    a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
        der.valid |-> ((der.valid_bytes != '0) && (der.valid_bytes <= VB_W'(8))))
        else $error("valid byte count out of range");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        der.valid |-> ((der.total_length >= TOT_W'(8))
                       && (der.total_length <= TOT_W'(MAX_TOTAL))))
        else $error("total length out of range");

endmodule

FILE: sim/tb_ecdsa_raw_to_der_signature_unit.sv
`timescale 1ns / 1ps
module tb_ecdsa_raw_to_der_signature_unit;
    import ecdsa_der_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS   = 10;
    localparam int RAW_W         = SIG_WORDS * WORD_W;
    localparam int INT_W         = INTEGER_BYTES * 8;

    // One DER word as it leaves the block
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [VB_W-1:0]   nbytes;
        logic [TOT_W-1:0]  total;
        logic              last;
    } der_beat_t;

    logic clk;
    logic rst_n;

    ecdsa_der_in_if  sig_ch();
    ecdsa_der_out_if der_ch();

    ecdsa_raw_to_der_signature_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sig   (sig_ch),
        .der   (der_ch)
    );

    // Encoder mirror: raw bytes, load position and the encoding being built
    logic [7:0]  sig_bytes [SIG_BYTES];
    logic [7:0]  der_bytes [MAX_TOTAL];
    int unsigned der_len;
    int unsigned words_in = 0;
    der_beat_t   der_beats_due [$];

    int unsigned fail_count         = 0;
    int unsigned beats_checked      = 0;
    int unsigned signatures_encoded = 0;
    int unsigned words_sent         = 0;
    int unsigned cycle_count        = 0;

    // Traffic shaping shared between the test tasks and the sink
    bit          tx_steady      = 1'b0;
    bit          rx_steady      = 1'b0;
    int unsigned rx_hold_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Append one INTEGER, stripping leading zeros and padding a set sign bit
    function automatic void put_integer(int unsigned base);
        int unsigned lead;
        logic        pad;
        lead = 0;
        while (lead < INTEGER_BYTES - 1 && sig_bytes[base + lead] == 8'h00)
            lead++;
        pad = (sig_bytes[base + lead] & SIGN_MASK) != 8'h00;
        der_bytes[der_len]     = TAG_INTEGER;
        der_bytes[der_len + 1] = 8'(INTEGER_BYTES - lead + pad);
        der_len += 2;
        if (pad)
        begin
            der_bytes[der_len] = PAD_BYTE;
            der_len++;
        end
        for (int i = lead; i < INTEGER_BYTES; i++)
        begin
            der_bytes[der_len] = sig_bytes[base + i];
            der_len++;
        end
    endfunction

    // Build the SEQUENCE and queue it as 8-byte words
    function automatic void encode_signature();
        der_beat_t   beat;
        int unsigned nbeats;
        int unsigned rem;
        foreach (der_bytes[i])
            der_bytes[i] = 8'h00;
        der_bytes[0] = TAG_SEQUENCE;
        der_len = 2;
        put_integer(0);
        put_integer(INTEGER_BYTES);
        der_bytes[1] = 8'(der_len - 2);
        nbeats = (der_len + 7) / 8;
        for (int k = 0; k < nbeats; k++)
        begin
            rem = der_len - 8 * k;
            beat.nbytes = VB_W'(rem < 8 ? rem : 8);
            beat.word   = '0;
            for (int b = 0; b < beat.nbytes; b++)
                beat.word[WORD_W-1-8*b -: 8] = der_bytes[8 * k + b];
            beat.total = TOT_W'(der_len);
            beat.last  = (k + 1 == nbeats);
            der_beats_due.push_back(beat);
        end
        signatures_encoded++;
    endfunction

    // Store the bytes of one accepted item; encode once the signature is complete
    function automatic void absorb_word(logic [WORD_W-1:0] w);
        for (int b = 0; b < 8; b++)
            if (words_in * 8 + b < SIG_BYTES)
                sig_bytes[words_in * 8 + b] = w[WORD_W-1-8*b -: 8];
        if (words_in + 1 < SIG_WORDS)
            words_in++;
        else
        begin
            words_in = 0;
            encode_signature();
        end
    endfunction

    // Compare one DER word with the oldest one due
    function automatic void check_beat(der_beat_t seen);
        der_beat_t due;
        if (der_beats_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected DER word: word=%h bytes=%0d total=%0d last=%0b",
                         seen.word, seen.nbytes, seen.total, seen.last);
        end
        else
        begin
            due = der_beats_due.pop_front();
            beats_checked++;
            if (seen.word !== due.word || seen.nbytes !== due.nbytes ||
                seen.total !== due.total || seen.last !== due.last)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("DER word %0d: expected word=%h bytes=%0d total=%0d last=%0b",
                             beats_checked, due.word, due.nbytes, due.total, due.last);
                    $display("              actual word=%h bytes=%0d total=%0d last=%0b",
                             seen.word, seen.nbytes, seen.total, seen.last);
                end
            end
        end
    endfunction

    // Watch both channels; check results before taking the new item
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (der_ch.valid === 1'b1 && der_ch.ready === 1'b1)
                check_beat('{der_ch.der_word, der_ch.valid_bytes,
                             der_ch.total_length, der_ch.last_word});
            if (sig_ch.valid === 1'b1 && sig_ch.ready === 1'b1)
                absorb_word(sig_ch.sig_word);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d DER words still due",
                     cycle_count, der_beats_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Result sink: random stall after each item unless rx_steady, plus requested hold-offs
    initial
    begin : der_sink
        int unsigned stall;
        stall = 0;
        der_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                der_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (stall > 0)
            begin
                der_ch.ready <= 1'b0;
                stall--;
            end
            else
                der_ch.ready <= 1'b1;
            @(posedge clk);
            if (der_ch.valid === 1'b1 && der_ch.ready === 1'b1)
                stall = rx_steady ? 0 : $urandom_range(0, 7);
        end
    end

    // Offer one item after a random gap, none when tx_steady, and hold it until accepted
    task automatic send_word(input logic [WORD_W-1:0] w);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            sig_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sig_ch.valid    <= 1'b1;
        sig_ch.sig_word <= w;
        @(posedge clk);
        while (sig_ch.ready !== 1'b1)
            @(posedge clk);
        words_sent++;
    endtask

    // Split r and s into words, first byte on top
    task automatic send_signature(input logic [INT_W-1:0] r, input logic [INT_W-1:0] s);
        logic [RAW_W-1:0] raw;
        raw = '0;
        raw[RAW_W-1 -: 2*INT_W] = {r, s};
        for (int w = 0; w < SIG_WORDS; w++)
            send_word(raw[RAW_W-1-WORD_W*w -: WORD_W]);
    endtask

    // Drop valid and wait until every expected DER word has come out
    task automatic wait_drained();
        sig_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (der_beats_due.size() != 0);
        @(posedge clk);
    endtask

    // Leading zero count: mostly none, some short runs, some long, some all zero
    function automatic int unsigned draw_lead();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return 0;
        else if (pick < 7)
            return $urandom_range(1, 3);
        else if (pick < 9)
            return $urandom_range(4, INTEGER_BYTES - 1);
        else
            return INTEGER_BYTES;
    endfunction

    // Integer with the given leading zero bytes and a nonzero first kept byte
    function automatic logic [INT_W-1:0] random_integer(int unsigned lead);
        logic [INT_W-1:0] v;
        logic [7:0]       octet;
        v = '0;
        for (int i = lead; i < INTEGER_BYTES; i++)
        begin
            octet = 8'($urandom);
            if (i == lead)
            begin
                if (octet == 8'h00)
                    octet = 8'h01;
            end
            else if ($urandom_range(0, 7) == 0)
                octet = 8'h00;
            v[INT_W-1-8*i -: 8] = octet;
        end
        return v;
    endfunction

    // Both integers zero: shortest encoding
    task automatic test_zero_integers();
        send_signature('0, '0);
        wait_drained();
    endtask

    // All bytes set: both integers padded, longest encoding
    task automatic test_sign_padding();
        send_signature('1, '1);
        wait_drained();
    endtask

    // Stripped zeros before a sign byte in r; s down to one small byte
    task automatic test_stripped_bytes();
        logic [INT_W-1:0] r;
        logic [INT_W-1:0] s;
        r = random_integer(2);
        r[INT_W-1-16 -: 8] = SIGN_MASK;
        s = '0;
        s[7:0] = 8'h7F;
        send_signature(r, s);
        wait_drained();
    endtask

    // No idling on either side
    task automatic test_back_to_back();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (3)
            send_signature(random_integer(draw_lead()), random_integer(draw_lead()));
        wait_drained();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Hold the output long enough that the block fills and stalls its input
    task automatic test_output_hold();
        tx_steady      = 1'b1;
        rx_hold_cycles = 400;
        repeat (3)
            send_signature(random_integer(draw_lead()), random_integer(draw_lead()));
        tx_steady = 1'b0;
        wait_drained();
    endtask

    // Mostly shaped signatures, some raw noise, random idling both sides
    task automatic test_random_signatures();
        for (int n = 0; n < 5; n++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                for (int w = 0; w < SIG_WORDS; w++)
                    send_word({$urandom, $urandom});
            end
            else
                send_signature(random_integer(draw_lead()), random_integer(draw_lead()));
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        sig_ch.valid    <= 1'b0;
        sig_ch.sig_word <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_integers();
        test_sign_padding();
        test_stripped_bytes();
        test_back_to_back();
        test_output_hold();
        test_random_signatures();

        // Let any stray output show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d signatures from %0d raw words, %0d DER words compared, %0d failures",
                 signatures_encoded, words_sent, beats_checked, fail_count);
        $display("covered zero, padded, stripped and noise integers, back-to-back traffic "
                 , "and a long output hold-off");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ecdsa_der_pkg.sv
rtl/ecdsa_der_in_if.sv
rtl/ecdsa_der_out_if.sv
rtl/ecdsa_der_seq.sv
rtl/ecdsa_der_pack.sv
rtl/ecdsa_raw_to_der_signature_unit.sv
sim/tb_ecdsa_raw_to_der_signature_unit.sv
